@@ sv/modexp_pkg.sv @@
// modexp_pkg: shared constants and types for the modular exponentiation block
// no dependencies
package modexp_pkg;
   localparam int OPERAND_BITS = 64;
   localparam int CNT_BITS = $clog2(OPERAND_BITS + 1);

   typedef logic [OPERAND_BITS-1:0] word_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_MUL,
      ST_SQR,
      ST_NEXT,
      ST_DONE
   } state_type;
endpackage

@@ sv/modexp_cell.sv @@
// modexp_cell: one bit cell of the modular double-and-add row
// no dependencies
module modexp_cell (
   input  logic acc_bit,
   input  logic add_bit,
   input  logic mod_bit,
   input  logic carry_in,
   input  logic borrow_in,
   output logic sum_bit,
   output logic carry_out,
   output logic diff_bit,
   output logic borrow_out
);
   assign sum_bit    = acc_bit ^ add_bit ^ carry_in;
   assign carry_out  = (acc_bit & add_bit) | (carry_in & (acc_bit ^ add_bit));
   assign diff_bit   = sum_bit ^ mod_bit ^ borrow_in;
   assign borrow_out = (~sum_bit & mod_bit) | (borrow_in & ~(sum_bit ^ mod_bit));
endmodule

@@ sv/modexp_mulmod.sv @@
// modexp_mulmod: bit-serial (a*b) mod m, doubling per b bit, adding on set bits
// depends on modexp_pkg and modexp_cell
module modexp_mulmod (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  modexp_pkg::word_type a,
   input  modexp_pkg::word_type b,
   input  modexp_pkg::word_type m,
   output modexp_pkg::word_type product,
   output logic                done
);
   localparam int N = modexp_pkg::OPERAND_BITS;

   modexp_pkg::word_type acc_ff, acc_in, addend;
   modexp_pkg::word_type bsh_ff, bsh_in;
   logic [modexp_pkg::CNT_BITS-1:0] cnt_ff, cnt_in;
   logic phase_ff, phase_in;
   logic busy_ff, busy_in;
   logic done_ff, done_in;

   logic [N:0] carry, borrow;
   modexp_pkg::word_type sum, diff;
   logic [N:0] sum_full;

   assign addend = phase_ff ? a : acc_ff;
   assign carry[0] = 1'b0;
   assign borrow[0] = 1'b0;

   for (genvar i = 0; i < N; i++) begin : g_row
      modexp_cell u_cell (
         .acc_bit(acc_ff[i]), .add_bit(addend[i]), .mod_bit(m[i]),
         .carry_in(carry[i]), .borrow_in(borrow[i]),
         .sum_bit(sum[i]), .carry_out(carry[i+1]),
         .diff_bit(diff[i]), .borrow_out(borrow[i+1])
      );
   end

   assign sum_full = {carry[N], sum};

   always_comb begin
      acc_in = acc_ff;
      bsh_in = bsh_ff;
      cnt_in = cnt_ff;
      phase_in = phase_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         acc_in = '0;
         bsh_in = b;
         cnt_in = '0;
         phase_in = 1'b0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (carry[N] | ~borrow[N]) acc_in = diff;
         else acc_in = sum_full[N-1:0];
         if (!phase_ff) begin
            if (!bsh_ff[N-1]) begin
               bsh_in = bsh_ff << 1;
               if (cnt_ff == modexp_pkg::CNT_BITS'(N - 1)) begin
                  busy_in = 1'b0;
                  done_in = 1'b1;
               end
               cnt_in = cnt_ff + 1'b1;
            end else begin
               phase_in = 1'b1;
            end
         end else begin
            phase_in = 1'b0;
            bsh_in = bsh_ff << 1;
            if (cnt_ff == modexp_pkg::CNT_BITS'(N - 1)) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      bsh_ff <= bsh_in;
      cnt_ff <= cnt_in;
      phase_ff <= phase_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign product = acc_ff;
   assign done = done_ff;
endmodule

@@ sv/modular_exponentiation_top.sv @@
// modular_exponentiation_top: right-to-left square-and-multiply exponentiation
// depends on modexp_pkg and modexp_mulmod
//
// usage: drive req_base, req_exponent, req_modulus and pulse start while busy is
// low; the request is taken at that edge and busy rises on the next cycle.
// rsp_valid is high for exactly one cycle with rsp_power_result and
// rsp_zero_modulus; the receiver cannot stall; rsp_valid drops after that cycle.
// a zero exponent or zero modulus goes straight to the done state and is answered
// through the valid register. otherwise the base is first reduced (one modular
// product of 1 by the base), then for each exponent bit up to the highest set bit
// there is a square and, on set bits, a multiply, with a pass through the next-bit
// state between bits. each modular product runs on the one shared bit-serial row
// of cells: a doubling step for each of the 64 multiplier bits, an adding step per
// set bit, then a hand-over through its registered done. one request at a time.
// reset: synchronous, clears the control state; no request is in flight after it.
module modular_exponentiation_top (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [63:0]         req_base,
   input  logic [63:0]         req_exponent,
   input  logic [63:0]         req_modulus,
   output logic                rsp_valid,
   output logic [63:0]         rsp_power_result,
   output logic                rsp_zero_modulus
);
   localparam int N = modexp_pkg::OPERAND_BITS;

   modexp_pkg::state_type state_ff, state_in;
   modexp_pkg::word_type base_ff, base_in, exp_ff, exp_in, mod_ff, r_ff, r_in;
   logic [63:0] res_ff, res_in;
   logic zm_ff, zm_in, valid_ff, valid_in;
   logic mm_start, mm_done;
   modexp_pkg::word_type mm_a, mm_b, mm_p;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         modexp_pkg::ST_IDLE:
            if (start) begin
               if (req_exponent[N-1:0] == '0 || req_modulus[N-1:0] == '0)
                  state_in = modexp_pkg::ST_DONE;
               else state_in = modexp_pkg::ST_REDUCE;
            end
         modexp_pkg::ST_REDUCE:
            if (mm_done) state_in = exp_ff[0] ? modexp_pkg::ST_MUL : modexp_pkg::ST_SQR;
         modexp_pkg::ST_MUL:
            if (mm_done) state_in = modexp_pkg::ST_SQR;
         modexp_pkg::ST_SQR:
            if (mm_done) state_in = modexp_pkg::ST_NEXT;
         modexp_pkg::ST_NEXT:
            if (exp_ff == '0) state_in = modexp_pkg::ST_DONE;
            else state_in = exp_ff[0] ? modexp_pkg::ST_MUL : modexp_pkg::ST_SQR;
         modexp_pkg::ST_DONE: state_in = modexp_pkg::ST_IDLE;
         default: state_in = modexp_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      base_in = base_ff;
      exp_in = exp_ff;
      r_in = r_ff;
      res_in = res_ff;
      zm_in = zm_ff;
      valid_in = 1'b0;
      mm_start = 1'b0;
      mm_a = base_ff;
      mm_b = base_ff;
      case (state_ff)
         modexp_pkg::ST_IDLE: begin
            if (start) begin
               base_in = req_base[N-1:0];
               exp_in = req_exponent[N-1:0];
               zm_in = 1'b0;
               if (req_exponent[N-1:0] == '0) res_in = 64'd1;
               else if (req_modulus[N-1:0] == '0) begin
                  res_in = '0;
                  zm_in = 1'b1;
               end else begin
                  mm_start = 1'b1;
                  mm_a = modexp_pkg::word_type'(1);
                  mm_b = req_base[N-1:0];
               end
            end
         end
         modexp_pkg::ST_REDUCE: begin
            mm_a = modexp_pkg::word_type'(1);
            if (mm_done) begin
               base_in = mm_p;
               r_in = modexp_pkg::word_type'(1);
               mm_start = 1'b1;
               mm_a = exp_ff[0] ? modexp_pkg::word_type'(1) : mm_p;
               mm_b = mm_p;
            end
         end
         modexp_pkg::ST_MUL: begin
            mm_a = r_ff;
            if (mm_done) begin
               r_in = mm_p;
               mm_start = 1'b1;
               mm_a = base_ff;
            end
         end
         modexp_pkg::ST_SQR: begin
            if (mm_done) begin
               base_in = mm_p;
               exp_in = exp_ff >> 1;
            end
         end
         modexp_pkg::ST_NEXT: begin
            if (exp_ff != '0) begin
               mm_start = 1'b1;
               mm_a = exp_ff[0] ? r_ff : base_ff;
            end else begin
               res_in = 64'(r_ff);
            end
         end
         modexp_pkg::ST_DONE: valid_in = 1'b1;
         default: valid_in = 1'b0;
      endcase
   end

   modexp_mulmod u_mulmod (
      .clock(clock), .reset(reset), .start(mm_start),
      .a(mm_a), .b(mm_b), .m(mod_ff), .product(mm_p), .done(mm_done)
   );

   always_ff @(posedge clock) begin
      base_ff <= base_in;
      exp_ff <= exp_in;
      r_ff <= r_in;
      res_ff <= res_in;
      zm_ff <= zm_in;
      if (state_ff == modexp_pkg::ST_IDLE && start) mod_ff <= req_modulus[N-1:0];
      if (reset) begin
         state_ff <= modexp_pkg::ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   assign busy = (state_ff != modexp_pkg::ST_IDLE);
   assign rsp_valid = valid_ff;
   assign rsp_power_result = res_ff;
   assign rsp_zero_modulus = zm_ff;
endmodule
